// ----- src/jsv_pkg.sv -----
// ----------------------------------------------------------------------------
// jsv_pkg
// Shared types, constants and character helpers of the JSON structure
// validator.
// ----------------------------------------------------------------------------
package jsv_pkg;

   localparam int MAX_DEPTH = 16;
   localparam int LEVEL_W   = $clog2(MAX_DEPTH + 1);
   localparam int ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W     = 17;
   localparam int MAX_W     = 16;

   localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 16'd1024;

   typedef enum logic [3:0] {
      PH_VALUE     = 4'd0,
      PH_STR_VAL   = 4'd1,
      PH_STR_KEY   = 4'd2,
      PH_LITERAL   = 4'd3,
      PH_NUMBER    = 4'd4,
      PH_AFTER     = 4'd5,
      PH_ARR_START = 4'd6,
      PH_ARR_NEXT  = 4'd7,
      PH_OBJ_START = 4'd8,
      PH_OBJ_NEXT  = 4'd9,
      PH_COLON     = 4'd10
   } phase_type;

   typedef enum logic {
      KIND_OBJ = 1'b0,
      KIND_ARR = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      LIT_TRUE  = 2'd0,
      LIT_FALSE = 2'd1,
      LIT_NULL  = 2'd2
   } lit_type;

   typedef enum logic [3:0] {
      ERR_NONE        = 4'd0,
      ERR_TRAILING    = 4'd1,
      ERR_DEPTH       = 4'd2,
      ERR_EARLY_END   = 4'd3,
      ERR_COLON       = 4'd4,
      ERR_OBJ_SEP     = 4'd5,
      ERR_OPEN_OBJ    = 4'd6,
      ERR_ARR_LIMIT   = 4'd7,
      ERR_ARR_SEP     = 4'd8,
      ERR_OPEN_ARR    = 4'd9,
      ERR_WANT_STRING = 4'd10,
      ERR_CTRL_CHAR   = 4'd11,
      ERR_OPEN_STRING = 4'd12,
      ERR_BAD_TOKEN   = 4'd13
   } err_type;

   typedef struct packed {
      kind_type         kind;
      logic [CNT_W-1:0] count;
   } stack_entry_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      stack_entry_type   wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic    valid;
      err_type code;
   } result_type;

   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_COLON    = 8'h3A;
   localparam logic [7:0] CH_LC_T     = 8'h74;
   localparam logic [7:0] CH_LC_F     = 8'h66;
   localparam logic [7:0] CH_LC_N     = 8'h6E;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
   endfunction

   function automatic logic is_num(input logic [7:0] b);
      return ((b >= 8'h30) && (b <= 8'h39)) || (b == 8'h2D) || (b == 8'h2B) ||
             (b == 8'h2E) || (b == 8'h65) || (b == 8'h45);
   endfunction

   function automatic logic [2:0] lit_len(input lit_type k);
      logic [2:0] len;
      unique case (k)
         LIT_FALSE: len = 3'd5;
         default:   len = 3'd4;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] lit_char(input lit_type k, input logic [2:0] idx);
      logic [39:0] text;
      logic [7:0]  c;
      unique case (k)
         LIT_FALSE: text = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
         LIT_NULL:  text = {8'h00, 8'h6C, 8'h6C, 8'h75, 8'h6E};
         default:   text = {8'h00, 8'h65, 8'h75, 8'h72, 8'h74};
      endcase
      unique case (idx)
         3'd0:    c = text[7:0];
         3'd1:    c = text[15:8];
         3'd2:    c = text[23:16];
         3'd3:    c = text[31:24];
         3'd4:    c = text[39:32];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- src/json_structure_validator_core.sv -----
// output: the verdict is registered in the output stage before it appears on rsp
// throughput: one byte per cycle while ready; the stack ram entry below the
//   top is prefetched every cycle so a close bracket never waits on the read port
// reset: synchronous, clears parse state and output stage, sets
//   max_array_entries to 1024; the stack ram is not cleared
// ----------------------------------------------------------------------------
// json_structure_validator_core
// Streaming JSON structure validator: one request byte per cycle while
// req_tready is high, one verdict per message with message_valid and error_code.
// ----------------------------------------------------------------------------
module json_structure_validator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] message_valid, [4:1] error_code, [7:5] zero
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data  // max_array_entries
);
   import jsv_pkg::*;

   logic            accept;
   ram_req_type     ram_req;
   stack_entry_type below;
   result_type      result;

   assign accept = req_tvalid && req_tready;

   jsv_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ram_req     (ram_req),
      .below       (below),
      .result      (result)
   );

   jsv_stack_ram u_stack_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (below)
   );

   jsv_rsp_skid u_rsp_skid (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .in_ready   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- src/jsv_stack_ram.sv -----
// ----------------------------------------------------------------------------
// jsv_stack_ram
// Frame stack storage below the top of stack: one write port, one registered
// read port, write data forwarded on a same-address read.
// ----------------------------------------------------------------------------
module jsv_stack_ram (
   input  logic                     clock,
   input  jsv_pkg::ram_req_type     ram_req,
   output jsv_pkg::stack_entry_type rd_data
);
   import jsv_pkg::*;

   stack_entry_type mem [MAX_DEPTH];
   stack_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.we && (ram_req.waddr == ram_req.raddr)) begin
         rd_data_ff <= ram_req.wdata;
      end else begin
         rd_data_ff <= mem[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/jsv_parser.sv -----
// ----------------------------------------------------------------------------
// jsv_parser
// Per-byte syntax state machine: top of stack in registers, the entry below
// it prefetched from the stack ram, verdict on the last byte.
// ----------------------------------------------------------------------------
module jsv_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   input  logic                     csr_wr_en,
   input  logic [15:0]              csr_wr_data,
   output jsv_pkg::ram_req_type     ram_req,
   input  jsv_pkg::stack_entry_type below,
   output jsv_pkg::result_type      result
);
   import jsv_pkg::*;

   logic [MAX_W-1:0]   max_ff;
   phase_type          phase_ff, phase_in, f_phase;
   logic [LEVEL_W-1:0] level_ff, level_in, f_level;
   kind_type           kind_ff, kind_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, cnt_upd;
   logic               esc_ff, esc_in, f_esc;
   lit_type            lit_ff, lit_in, f_lit;
   logic [2:0]         idx_ff, idx_in, f_idx;
   err_type            err_ff, err_in, f_err;
   err_type            raise, end_code;
   logic               do_value, do_after, do_pop, do_push;
   kind_type           push_kind;
   phase_type          push_phase;
   logic               top_ok;
   logic [LEVEL_W-1:0] rd_level;

   assign top_ok = (level_ff != '0) && (level_ff <= LEVEL_W'(MAX_DEPTH));

   always_comb begin
      f_phase    = phase_ff;
      f_level    = level_ff;
      f_esc      = esc_ff;
      f_lit      = lit_ff;
      f_idx      = idx_ff;
      kind_in    = kind_ff;
      cnt_upd    = cnt_ff;
      cnt_in     = cnt_ff;
      raise      = ERR_NONE;
      do_value   = 1'b0;
      do_after   = 1'b0;
      do_pop     = 1'b0;
      do_push    = 1'b0;
      push_kind  = KIND_OBJ;
      push_phase = PH_OBJ_START;
      ram_req.we    = 1'b0;
      ram_req.waddr = ADDR_W'(level_ff - LEVEL_W'(1));
      ram_req.wdata = '{kind: kind_ff, count: cnt_ff};
      if (err_ff == ERR_NONE) begin
         unique case (phase_ff)
            PH_VALUE: do_value = 1'b1;
            PH_STR_VAL, PH_STR_KEY: begin
               if (esc_ff) begin
                  f_esc = 1'b0;
               end else if (data_byte == CH_BSLASH) begin
                  f_esc = 1'b1;
               end else if (data_byte == CH_QUOTE) begin
                  f_phase = (phase_ff == PH_STR_KEY) ? PH_COLON : PH_AFTER;
               end else if (data_byte < CH_SPACE) begin
                  raise = ERR_CTRL_CHAR;
               end
            end
            PH_LITERAL: begin
               if ((idx_ff < lit_len(lit_ff)) && (data_byte == lit_char(lit_ff, idx_ff))) begin
                  f_idx = idx_ff + 3'd1;
                  if ((idx_ff + 3'd1) == lit_len(lit_ff)) begin
                     f_phase = PH_AFTER;
                  end
               end else begin
                  raise = ERR_BAD_TOKEN;
               end
            end
            PH_NUMBER: begin
               if (!is_num(data_byte)) begin
                  do_after = 1'b1;
               end
            end
            PH_AFTER: do_after = 1'b1;
            PH_ARR_START, PH_ARR_NEXT: begin
               if ((phase_ff == PH_ARR_START) && is_ws(data_byte)) begin
                  f_phase = phase_ff;
               end else if ((phase_ff == PH_ARR_START) && (data_byte == CH_RBRACKET)) begin
                  do_pop = 1'b1;
               end else if (!top_ok) begin
                  raise = ERR_OPEN_ARR;
               end else begin
                  if (cnt_ff <= CNT_W'(max_ff)) begin
                     cnt_upd = cnt_ff + CNT_W'(1);
                  end
                  cnt_in = cnt_upd;
                  if (cnt_upd > CNT_W'(max_ff)) begin
                     raise = ERR_ARR_LIMIT;
                  end else if (level_ff >= LEVEL_W'(MAX_DEPTH)) begin
                     raise = ERR_DEPTH;
                  end else begin
                     do_value = 1'b1;
                  end
               end
            end
            PH_OBJ_START, PH_OBJ_NEXT: begin
               if (is_ws(data_byte)) begin
                  f_phase = phase_ff;
               end else if ((phase_ff == PH_OBJ_START) && (data_byte == CH_RBRACE)) begin
                  do_pop = 1'b1;
               end else if (data_byte == CH_QUOTE) begin
                  f_esc   = 1'b0;
                  f_phase = PH_STR_KEY;
               end else begin
                  raise = ERR_WANT_STRING;
               end
            end
            PH_COLON: begin
               if (is_ws(data_byte)) begin
                  f_phase = phase_ff;
               end else if (data_byte != CH_COLON) begin
                  raise = ERR_COLON;
               end else if (level_ff >= LEVEL_W'(MAX_DEPTH)) begin
                  raise = ERR_DEPTH;
               end else begin
                  f_phase = PH_VALUE;
               end
            end
            default: raise = ERR_BAD_TOKEN;
         endcase

         if (do_value) begin
            priority if (is_ws(data_byte)) begin
               f_phase = PH_VALUE;
            end else if (data_byte == CH_LBRACE) begin
               do_push    = 1'b1;
               push_kind  = KIND_OBJ;
               push_phase = PH_OBJ_START;
            end else if (data_byte == CH_LBRACKET) begin
               do_push    = 1'b1;
               push_kind  = KIND_ARR;
               push_phase = PH_ARR_START;
            end else if (data_byte == CH_QUOTE) begin
               f_esc   = 1'b0;
               f_phase = PH_STR_VAL;
            end else if ((data_byte == CH_LC_T) || (data_byte == CH_LC_F) ||
                         (data_byte == CH_LC_N)) begin
               f_lit   = (data_byte == CH_LC_T) ? LIT_TRUE :
                         (data_byte == CH_LC_F) ? LIT_FALSE : LIT_NULL;
               f_idx   = 3'd1;
               f_phase = PH_LITERAL;
            end else if (is_num(data_byte)) begin
               f_phase = PH_NUMBER;
            end else begin
               raise = ERR_BAD_TOKEN;
            end
         end

         if (do_after) begin
            f_phase = PH_AFTER;
            if (is_ws(data_byte)) begin
               f_phase = PH_AFTER;
            end else if (!top_ok) begin
               raise = ERR_TRAILING;
            end else if (kind_ff == KIND_ARR) begin
               if (data_byte == CH_RBRACKET) begin
                  do_pop = 1'b1;
               end else if (data_byte == CH_COMMA) begin
                  f_phase = PH_ARR_NEXT;
               end else begin
                  raise = ERR_ARR_SEP;
               end
            end else begin
               if (data_byte == CH_RBRACE) begin
                  do_pop = 1'b1;
               end else if (data_byte == CH_COMMA) begin
                  f_phase = PH_OBJ_NEXT;
               end else begin
                  raise = ERR_OBJ_SEP;
               end
            end
         end

         if (do_push) begin
            if (level_ff >= LEVEL_W'(MAX_DEPTH)) begin
               raise = ERR_DEPTH;
            end else begin
               ram_req.we    = accept && (level_ff != '0);
               ram_req.wdata = '{kind: kind_ff, count: cnt_upd};
               kind_in       = push_kind;
               cnt_in        = '0;
               f_level       = level_ff + LEVEL_W'(1);
               f_phase       = push_phase;
            end
         end

         if (do_pop) begin
            if (level_ff != '0) begin
               f_level = level_ff - LEVEL_W'(1);
            end
            kind_in = below.kind;
            cnt_in  = below.count;
            f_phase = PH_AFTER;
         end
      end
      f_err = (err_ff != ERR_NONE) ? err_ff : raise;
   end

   always_comb begin
      end_code = f_err;
      if (f_err == ERR_NONE) begin
         unique case (f_phase)
            PH_VALUE:                  end_code = ERR_EARLY_END;
            PH_STR_VAL, PH_STR_KEY:    end_code = ERR_OPEN_STRING;
            PH_LITERAL:                end_code = ERR_BAD_TOKEN;
            PH_NUMBER, PH_AFTER: begin
               if ((f_level == '0) || (f_level > LEVEL_W'(MAX_DEPTH))) begin
                  end_code = ERR_NONE;
               end else if (kind_in == KIND_ARR) begin
                  end_code = ERR_ARR_SEP;
               end else begin
                  end_code = ERR_OBJ_SEP;
               end
            end
            PH_ARR_START, PH_ARR_NEXT: end_code = ERR_OPEN_ARR;
            PH_OBJ_START, PH_OBJ_NEXT: end_code = ERR_OPEN_OBJ;
            PH_COLON:                  end_code = ERR_COLON;
            default:                   end_code = ERR_BAD_TOKEN;
         endcase
      end
   end

   always_comb begin
      if (last_byte) begin
         phase_in = PH_VALUE;
         level_in = '0;
         esc_in   = 1'b0;
         lit_in   = LIT_TRUE;
         idx_in   = 3'd0;
         err_in   = ERR_NONE;
      end else begin
         phase_in = f_phase;
         level_in = f_level;
         esc_in   = f_esc;
         lit_in   = f_lit;
         idx_in   = f_idx;
         err_in   = f_err;
      end
   end

   // prefetch the entry below the next top of stack
   assign rd_level      = (accept ? level_in : level_ff) - LEVEL_W'(2);
   assign ram_req.raddr = rd_level[ADDR_W-1:0];

   assign result.valid = accept && last_byte;
   assign result.code  = end_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_ENTRIES_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VALUE;
         level_ff <= '0;
         esc_ff   <= 1'b0;
         lit_ff   <= LIT_TRUE;
         idx_ff   <= 3'd0;
         err_ff   <= ERR_NONE;
      end else if (accept) begin
         phase_ff <= phase_in;
         level_ff <= level_in;
         esc_ff   <= esc_in;
         lit_ff   <= lit_in;
         idx_ff   <= idx_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_in;
         cnt_ff  <= cnt_in;
      end
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(MAX_DEPTH))
      else $error("stack level beyond limit");

   a_clear_after_verdict: assert property (@(posedge clock) disable iff (reset)
      (accept && last_byte) |=> (level_ff == '0 && err_ff == ERR_NONE &&
                                 phase_ff == PH_VALUE))
      else $error("parse state not cleared after verdict");

   a_error_latched: assert property (@(posedge clock) disable iff (reset)
      (accept && !last_byte && err_ff != ERR_NONE) |=> $stable(err_ff))
      else $error("latched error changed");

   a_push_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> (level_ff != '0 && level_ff < LEVEL_W'(MAX_DEPTH)))
      else $error("stack write out of range");

endmodule

// ----- src/jsv_rsp_skid.sv -----
// ----------------------------------------------------------------------------
// jsv_rsp_skid
// Two-entry output stage for verdicts: main register plus skid register.
// ----------------------------------------------------------------------------
module jsv_rsp_skid (
   input  logic                clock,
   input  logic                reset,
   input  jsv_pkg::result_type result,
   output logic                in_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata
);
   import jsv_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   err_type main_ff, main_in;
   err_type skid_ff, skid_in;
   logic    take;

   assign take     = main_valid_ff && rsp_tready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result.valid) begin
         if (!main_valid_ff || take) begin
            main_in       = result.code;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = result.code;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {3'b000, main_ff, (main_ff == ERR_NONE)};

   a_skid_implies_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry without main entry");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !result.valid)
      else $error("verdict arrived with both entries full");

   a_drain_order: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> (main_valid_ff && main_ff == $past(skid_ff)))
      else $error("skid entry lost on drain");

endmodule

// ----- verif/tb_json_structure_validator_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_structure_validator_core
// Streams JSON messages one byte per request into the validator and checks
// every verdict against a parser model kept in the bench. Short hand-picked
// messages cover each error code, the nesting depth and the array entry
// limit, then random well-formed, damaged and noise messages run under
// several entry limits and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_json_structure_validator_core;
   import jsv_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [0] message_valid, [4:1] error_code, [7:5] zero
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   json_structure_validator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser model state
   phase_type   parse_phase = PH_VALUE;
   kind_type    open_kind [MAX_DEPTH];
   int unsigned open_count [MAX_DEPTH];
   int          level = 0;
   bit          esc_pend = 1'b0;
   lit_type     lit_sel = LIT_TRUE;
   int          lit_pos = 0;
   err_type     latched_err = ERR_NONE;
   int          entry_limit = int'(MAX_ENTRIES_RESET);

   err_type     verdict_q [$];
   int          verdict_errors = 0;
   int          bytes_sent = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   logic [7:0]  msg_buf [$];

   function automatic bit is_blank(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
   endfunction

   function automatic bit in_number_class(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || b == 8'h2B || b == 8'h2D || b == 8'h2E ||
             b == 8'h65 || b == 8'h45;
   endfunction

   function automatic string keyword_text(input lit_type k);
      string w;
      case (k)
         LIT_FALSE: w = "false";
         LIT_NULL:  w = "null";
         default:   w = "true";
      endcase
      return w;
   endfunction

   function automatic void note_error(input err_type c);
      if (latched_err == ERR_NONE) latched_err = c;
   endfunction

   function automatic bit level_ok();
      return level >= 1 && level <= MAX_DEPTH;
   endfunction

   function automatic void open_frame(input kind_type k, input phase_type next);
      if (level >= MAX_DEPTH) begin
         note_error(ERR_DEPTH);
      end else begin
         open_kind[level] = k;
         open_count[level] = 0;
         level++;
         parse_phase = next;
      end
   endfunction

   function automatic void close_frame();
      if (level > 0) level--;
      parse_phase = PH_AFTER;
   endfunction

   function automatic void clear_parse();
      parse_phase = PH_VALUE;
      level = 0;
      esc_pend = 1'b0;
      lit_sel = LIT_TRUE;
      lit_pos = 0;
      latched_err = ERR_NONE;
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      bit    again;
      int    top;
      string word;
      again = 1'b1;
      while (again && latched_err == ERR_NONE) begin
         again = 1'b0;
         case (parse_phase)
            PH_VALUE: begin
               if (b == CH_LBRACE) open_frame(KIND_OBJ, PH_OBJ_START);
               else if (b == CH_LBRACKET) open_frame(KIND_ARR, PH_ARR_START);
               else if (b == CH_QUOTE) begin
                  esc_pend = 1'b0;
                  parse_phase = PH_STR_VAL;
               end else if (b == CH_LC_T || b == CH_LC_F || b == CH_LC_N) begin
                  lit_sel = (b == CH_LC_T) ? LIT_TRUE : (b == CH_LC_F) ? LIT_FALSE : LIT_NULL;
                  lit_pos = 1;
                  parse_phase = PH_LITERAL;
               end else if (in_number_class(b)) parse_phase = PH_NUMBER;
               else if (!is_blank(b)) note_error(ERR_BAD_TOKEN);
            end
            PH_STR_VAL, PH_STR_KEY: begin
               if (esc_pend) esc_pend = 1'b0;
               else if (b == CH_BSLASH) esc_pend = 1'b1;
               else if (b == CH_QUOTE)
                  parse_phase = (parse_phase == PH_STR_KEY) ? PH_COLON : PH_AFTER;
               else if (b < 8'h20) note_error(ERR_CTRL_CHAR);
            end
            PH_LITERAL: begin
               word = keyword_text(lit_sel);
               if (lit_pos < word.len() && b == word[lit_pos]) begin
                  lit_pos++;
                  if (lit_pos == word.len()) parse_phase = PH_AFTER;
               end else begin
                  note_error(ERR_BAD_TOKEN);
               end
            end
            PH_NUMBER: begin
               if (!in_number_class(b)) begin
                  parse_phase = PH_AFTER;
                  again = 1'b1;
               end
            end
            PH_AFTER: begin
               if (!is_blank(b)) begin
                  if (!level_ok()) note_error(ERR_TRAILING);
                  else if (open_kind[level-1] == KIND_ARR) begin
                     if (b == CH_RBRACKET) close_frame();
                     else if (b == CH_COMMA) parse_phase = PH_ARR_NEXT;
                     else note_error(ERR_ARR_SEP);
                  end else begin
                     if (b == CH_RBRACE) close_frame();
                     else if (b == CH_COMMA) parse_phase = PH_OBJ_NEXT;
                     else note_error(ERR_OBJ_SEP);
                  end
               end
            end
            PH_ARR_START, PH_ARR_NEXT: begin
               if (parse_phase == PH_ARR_START && b == CH_RBRACKET) close_frame();
               else if (!(parse_phase == PH_ARR_START && is_blank(b))) begin
                  if (!level_ok()) note_error(ERR_OPEN_ARR);
                  else begin
                     top = level - 1;
                     if (open_count[top] <= entry_limit) open_count[top]++;
                     if (open_count[top] > entry_limit) note_error(ERR_ARR_LIMIT);
                     else if (level >= MAX_DEPTH) note_error(ERR_DEPTH);
                     else begin
                        parse_phase = PH_VALUE;
                        again = 1'b1;
                     end
                  end
               end
            end
            PH_OBJ_START, PH_OBJ_NEXT: begin
               if (!is_blank(b)) begin
                  if (parse_phase == PH_OBJ_START && b == CH_RBRACE) close_frame();
                  else if (b == CH_QUOTE) begin
                     esc_pend = 1'b0;
                     parse_phase = PH_STR_KEY;
                  end else note_error(ERR_WANT_STRING);
               end
            end
            PH_COLON: begin
               if (!is_blank(b)) begin
                  if (b != CH_COLON) note_error(ERR_COLON);
                  else if (level >= MAX_DEPTH) note_error(ERR_DEPTH);
                  else parse_phase = PH_VALUE;
               end
            end
            default: note_error(ERR_BAD_TOKEN);
         endcase
      end
   endfunction

   function automatic err_type verdict_code();
      err_type c;
      if (latched_err != ERR_NONE) return latched_err;
      case (parse_phase)
         PH_VALUE:                 c = ERR_EARLY_END;
         PH_STR_VAL, PH_STR_KEY:   c = ERR_OPEN_STRING;
         PH_LITERAL:               c = ERR_BAD_TOKEN;
         PH_NUMBER, PH_AFTER: begin
            if (!level_ok()) c = ERR_NONE;
            else c = (open_kind[level-1] == KIND_ARR) ? ERR_ARR_SEP : ERR_OBJ_SEP;
         end
         PH_ARR_START, PH_ARR_NEXT: c = ERR_OPEN_ARR;
         PH_OBJ_START, PH_OBJ_NEXT: c = ERR_OPEN_OBJ;
         PH_COLON:                 c = ERR_COLON;
         default:                  c = ERR_BAD_TOKEN;
      endcase
      return c;
   endfunction

   // request tracking and verdict checking
   always @(posedge clock) begin : verdict_monitor
      err_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata);
            if (req_tlast) begin
               verdict_q.push_back(verdict_code());
               clear_parse();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: verdict with none pending, expected nothing actual tdata %h",
                        $time, rsp_tdata);
               verdict_errors++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[0] !== (want == ERR_NONE)) begin
                  $display("%0t: message_valid expected %0b actual %0b",
                           $time, want == ERR_NONE, rsp_tdata[0]);
                  verdict_errors++;
               end
               if (rsp_tdata[4:1] !== want) begin
                  $display("%0t: error_code expected %0d actual %0d",
                           $time, want, rsp_tdata[4:1]);
                  verdict_errors++;
               end
               if (rsp_tdata[7:5] !== 3'b000) begin
                  $display("%0t: tdata pad expected 0 actual %b", $time, rsp_tdata[7:5]);
                  verdict_errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_message();
      int i;
      for (i = 0; i < msg_buf.size(); i++)
         send_byte(msg_buf[i], i == msg_buf.size() - 1);
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      msg_buf.delete();
      add_text(s);
      send_message();
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_entry_limit(input logic [15:0] v);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      entry_limit = int'(v);
   endtask

   // random message building
   task automatic add_blank();
      logic [7:0] pick [4];
      pick = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
      if ($urandom_range(99) < 20) msg_buf.push_back(pick[$urandom_range(3)]);
   endtask

   task automatic add_string_body();
      int         n;
      int         r;
      logic [7:0] c;
      n = $urandom_range(0, 6);
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 10) begin
            msg_buf.push_back(CH_BSLASH);
            msg_buf.push_back(8'($urandom_range(255)));
         end else if (r < 12) begin
            msg_buf.push_back(8'($urandom_range(31)));
         end else begin
            c = 8'($urandom_range(255, 32));
            if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h61;
            msg_buf.push_back(c);
         end
      end
   endtask

   task automatic add_key();
      add_blank();
      msg_buf.push_back(CH_QUOTE);
      add_string_body();
      msg_buf.push_back(CH_QUOTE);
      add_blank();
      msg_buf.push_back(CH_COLON);
      add_blank();
   endtask

   task automatic add_scalar();
      string digits;
      digits = "0123456789+-.eE";
      case ($urandom_range(2))
         0: repeat ($urandom_range(1, 5)) msg_buf.push_back(digits[$urandom_range(14)]);
         1: begin
            msg_buf.push_back(CH_QUOTE);
            add_string_body();
            msg_buf.push_back(CH_QUOTE);
         end
         default: add_text(keyword_text(lit_type'($urandom_range(2))));
      endcase
   endtask

   task automatic build_random_message(input int depth_cap, input int budget,
                                       input int open_pct);
      kind_type stk [20];
      int       d;
      bit       need_val;
      bit       done;
      msg_buf.delete();
      d = 0;
      need_val = 1'b1;
      done = 1'b0;
      add_blank();
      while (!done) begin
         if (need_val) begin
            if (d < depth_cap && msg_buf.size() < budget && $urandom_range(99) < open_pct) begin
               stk[d] = kind_type'($urandom_range(1));
               msg_buf.push_back(stk[d] == KIND_ARR ? CH_LBRACKET : CH_LBRACE);
               d++;
               add_blank();
               if ($urandom_range(4) == 0) begin
                  d--;
                  msg_buf.push_back(stk[d] == KIND_ARR ? CH_RBRACKET : CH_RBRACE);
                  need_val = 1'b0;
               end else if (stk[d-1] == KIND_OBJ) begin
                  add_key();
               end
            end else begin
               add_scalar();
               need_val = 1'b0;
            end
         end else if (d == 0) begin
            add_blank();
            done = 1'b1;
         end else begin
            add_blank();
            if (msg_buf.size() < budget && $urandom_range(2) != 0) begin
               msg_buf.push_back(CH_COMMA);
               add_blank();
               if (stk[d-1] == KIND_OBJ) add_key();
               need_val = 1'b1;
            end else begin
               d--;
               msg_buf.push_back(stk[d] == KIND_ARR ? CH_RBRACKET : CH_RBRACE);
            end
         end
      end
   endtask

   task automatic damage_message();
      int pos;
      pos = $urandom_range(msg_buf.size() - 1);
      case ($urandom_range(3))
         0: repeat (msg_buf.size() - 1 - pos) void'(msg_buf.pop_back());
         1: msg_buf[pos] = 8'($urandom_range(255));
         2: msg_buf.insert(pos, 8'($urandom_range(255)));
         default: msg_buf.push_back(8'($urandom_range(255)));
      endcase
   endtask

   task automatic build_noise_message();
      string marks;
      marks = "{}[],:\" tfn0\\";
      msg_buf.delete();
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(1) == 0) msg_buf.push_back(marks[$urandom_range(marks.len() - 1)]);
         else msg_buf.push_back(8'($urandom_range(255)));
      end
   endtask

   // tests
   task automatic test_directed_tokens();
      idle_pct = 0;
      stall_pct = 0;
      send_text("0");
      send_text(" ");
      send_text("x}");
      send_text("fals");
      send_text("\"\\");
      send_text("[");
      send_text("{");
      send_text("{\"\"");
      send_text("[1 2");
      send_text("0 0");
      send_text("{\"\":1");
      send_text("{1");
      msg_buf = '{8'h00};
      send_message();
      msg_buf = '{CH_QUOTE, 8'h1F, CH_QUOTE};
      send_message();
      msg_buf = '{CH_QUOTE, 8'hFF, CH_QUOTE};
      send_message();
      send_text("{\"\":[null]}");
   endtask

   task automatic test_nesting_depth();
      msg_buf.delete();
      repeat (MAX_DEPTH) msg_buf.push_back(CH_LBRACKET);
      repeat (MAX_DEPTH) msg_buf.push_back(CH_RBRACKET);
      send_message();
      msg_buf.delete();
      repeat (MAX_DEPTH + 1) msg_buf.push_back(CH_LBRACKET);
      send_message();
      msg_buf.delete();
      repeat (MAX_DEPTH - 1) msg_buf.push_back(CH_LBRACKET);
      add_text("{\"\":");
      send_message();
   endtask

   task automatic test_array_limit();
      write_entry_limit(16'd0);
      send_text("[]");
      send_text("[1]");
      write_entry_limit(16'd1);
      send_text("[1]");
      send_text("[ 1,2]");
      write_entry_limit(16'd2);
      send_text("[[1, 2],[3]]");
   endtask

   task automatic test_random_messages();
      int mode;
      int goal;
      int r;
      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin
               write_entry_limit(16'hFFFF);
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               write_entry_limit(16'd1);
               idle_pct = 72;
               stall_pct = 0;
            end
            2: begin
               write_entry_limit(16'($urandom_range(5, 2)));
               idle_pct = 0;
               stall_pct = 72;
            end
            default: begin
               write_entry_limit(MAX_ENTRIES_RESET);
               idle_pct = 24;
               stall_pct = 24;
            end
         endcase
         goal = bytes_sent + 370;
         while (bytes_sent < goal) begin
            if ($urandom_range(99) < 5) build_random_message(MAX_DEPTH + 1, 80, 90);
            else build_random_message($urandom_range(4), $urandom_range(30, 4), 40);
            r = $urandom_range(99);
            if (r < 10) build_noise_message();
            else if (r < 30) damage_message();
            send_message();
         end
      end
   endtask

   initial begin
      int guard;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_tokens();
      test_nesting_depth();
      test_array_limit();
      test_random_messages();
      req_tvalid <= 1'b0;
      guard = 0;
      while (verdict_q.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (5) @(posedge clock);
      if (verdict_q.size() != 0) begin
         $display("%0t: verdicts expected %0d more actual 0", $time, verdict_q.size());
         verdict_errors++;
      end
      if (verdict_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
src/jsv_pkg.sv
src/jsv_stack_ram.sv
src/jsv_parser.sv
src/jsv_rsp_skid.sv
src/json_structure_validator_core.sv
verif/tb_json_structure_validator_core.sv
